[sv/spq_pkg.sv]
// spq_pkg: request/response types and codes for the sorted event priority queue.
// No dependencies; imported by spq_cmp and sorted_event_priority_queue, not by spq_ram.
package spq_pkg;

  localparam int unsigned KeyBits   = 32;
  localparam int unsigned TagBits   = 16;
  localparam int unsigned CountBits = 7;
  localparam int unsigned EntryBits = KeyBits + TagBits;

  typedef enum logic [0:0] {
    CmdInsert  = 1'b0,
    CmdExtract = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [KeyBits-1:0] key;
    logic [TagBits-1:0] tag;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic                 item_valid;
    logic [KeyBits-1:0]   out_key;
    logic [TagBits-1:0]   out_tag;
    logic [CountBits-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic ge;
    logic gt;
  } cmp_t;

endpackage

[sv/spq_ram.sv]
// spq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module spq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/spq_cmp.sv]
// spq_cmp: key comparator used by the insert search.
// Depends on spq_pkg.
module spq_cmp (
  input  logic [spq_pkg::KeyBits-1:0] a_i,
  input  logic [spq_pkg::KeyBits-1:0] b_i,
  output spq_pkg::cmp_t               res_o
);

  import spq_pkg::*;

  always_comb begin
    res_o.ge = (a_i >= b_i);
    res_o.gt = (a_i > b_i);
  end

endmodule

[sv/sorted_event_priority_queue.sv]
// sorted_event_priority_queue: bounded min-priority queue kept sorted in one RAM.
// Depends on spq_pkg, spq_ram, spq_cmp.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+--------------------
//   request | in_valid_i | in_stall_o | in_req_i  (req_t)
//   result  | out_valid_o| out_stall_i| out_rsp_o (rsp_t)
//
// Insert of a key landing at slot p of n entries walks the tail down one slot a cycle
// through the single RAM write port. Extract moves the remaining entries up one slot;
// a full insert or an empty extract goes straight to the result.
// The result register frees the input side; a held result delays only the next finish.
// Reset clears the count; RAM contents are only read below the count.
module sorted_event_priority_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::rsp_t out_rsp_o
);

  import spq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    StIdle,
    StInsShift,
    StInsPlace,
    StExtShift,
    StFinish
  } state_e;

  state_e               state_q, state_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        cnt_next_q, cnt_next_d;
  logic [KeyBits-1:0]   key_q, key_d;
  logic [TagBits-1:0]   tag_q, tag_d;
  status_e              res_status_q, res_status_d;
  logic                 res_hold_q, res_hold_d;
  logic [KeyBits-1:0]   res_key_q, res_key_d;
  logic [TagBits-1:0]   res_tag_q, res_tag_d;
  logic [KeyBits-1:0]   head_key_q, head_key_d;
  logic [TagBits-1:0]   head_tag_q, head_tag_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 out_rsp_q, out_rsp_d;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [EntryBits-1:0] ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [EntryBits-1:0] ram_rdata;
  logic [KeyBits-1:0]   rd_key;
  logic [TagBits-1:0]   rd_tag;
  cmp_t                 cmp;
  logic [IW-1:0]        j;
  logic                 do_shift;
  logic                 accept;

  assign accept      = in_valid_i && (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign rd_key      = ram_rdata[EntryBits-1:TagBits];
  assign rd_tag      = ram_rdata[TagBits-1:0];
  assign j           = idx_q - 1'b1;
  assign do_shift    = (j != '0) ? cmp.ge : cmp.gt;

  spq_ram #(
    .Width (EntryBits),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spq_cmp u_cmp (
    .a_i   (rd_key),
    .b_i   (key_q),
    .res_o (cmp)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    cnt_next_d   = cnt_next_q;
    key_d        = key_q;
    tag_d        = tag_q;
    res_status_d = res_status_q;
    res_hold_d   = res_hold_q;
    res_key_d    = res_key_q;
    res_tag_d    = res_tag_q;
    head_key_d   = head_key_q;
    head_tag_d   = head_tag_q;
    out_valid_d  = out_valid_q;
    out_rsp_d    = out_rsp_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = {key_q, tag_q};
    ram_raddr    = idx_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          key_d        = in_req_i.key;
          tag_d        = in_req_i.tag;
          res_status_d = StatusOk;
          res_hold_d   = 1'b0;
          cnt_next_d   = count_q;
          state_d      = StFinish;
          if (in_req_i.cmd == CmdInsert) begin
            if (count_q == CW'(DEPTH)) begin
              res_status_d = StatusFull;
            end else if (count_q == '0) begin
              ram_we     = 1'b1;
              ram_waddr  = '0;
              ram_wdata  = {in_req_i.key, in_req_i.tag};
              head_key_d = in_req_i.key;
              head_tag_d = in_req_i.tag;
              cnt_next_d = count_q + 1'b1;
            end else begin
              ram_raddr  = IW'(count_q - 1'b1);
              idx_d      = IW'(count_q);
              cnt_next_d = count_q + 1'b1;
              state_d    = StInsShift;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = StatusEmpty;
            end else begin
              res_hold_d = 1'b1;
              res_key_d  = head_key_q;
              res_tag_d  = head_tag_q;
              cnt_next_d = count_q - 1'b1;
              if (count_q != CW'(1)) begin
                ram_raddr = IW'(1);
                idx_d     = IW'(1);
                state_d   = StExtShift;
              end
            end
          end
        end
      end
      StInsShift: begin
        ram_we = 1'b1;
        if (do_shift) begin
          ram_wdata = ram_rdata;
          if (j == '0) begin
            idx_d   = '0;
            state_d = StInsPlace;
          end else begin
            ram_raddr = j - 1'b1;
            idx_d     = j;
          end
        end else begin
          state_d = StFinish;
        end
      end
      StInsPlace: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        head_key_d = key_q;
        head_tag_d = tag_q;
        state_d    = StFinish;
      end
      StExtShift: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = ram_rdata;
        if (j == '0) begin
          head_key_d = rd_key;
          head_tag_d = rd_tag;
        end
        if (CW'(idx_q) + 1'b1 == count_q) begin
          state_d = StFinish;
        end else begin
          ram_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          count_d              = cnt_next_q;
          out_rsp_d.status     = res_status_q;
          out_rsp_d.count      = CountBits'(cnt_next_q);
          if (res_hold_q) begin
            out_rsp_d.item_valid = 1'b1;
            out_rsp_d.out_key    = res_key_q;
            out_rsp_d.out_tag    = res_tag_q;
          end else if (cnt_next_q != '0) begin
            out_rsp_d.item_valid = 1'b1;
            out_rsp_d.out_key    = head_key_q;
            out_rsp_d.out_tag    = head_tag_q;
          end else begin
            out_rsp_d.item_valid = 1'b0;
            out_rsp_d.out_key    = '0;
            out_rsp_d.out_tag    = '0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cnt_next_q   <= cnt_next_d;
    key_q        <= key_d;
    tag_q        <= tag_d;
    res_status_q <= res_status_d;
    res_hold_q   <= res_hold_d;
    res_key_q    <= res_key_d;
    res_tag_q    <= res_tag_d;
    head_key_q   <= head_key_d;
    head_tag_q   <= head_tag_d;
    out_rsp_q    <= out_rsp_d;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted but sequencer stayed idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_ram_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != StIdle) || accept)
    else $error("RAM written with no request in progress");

  a_count_moves_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> out_valid_q)
    else $error("entry count changed without a result");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for sorted_event_priority_queue, with a directed table
// and then random insert/extract traffic, each reply compared with a local queue model or a fixed table reply.
// Depends on spq_pkg and the sorted_event_priority_queue RTL.
module tb_top;
  import spq_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned N_RANDOM   = 1330;
  localparam rsp_t        NO_REPLY   = '0;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t exp;
  } row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_stall_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  // model of the sorted store, slot 0 is the head
  logic [KeyBits-1:0] slot_key [DEPTH];
  logic [TagBits-1:0] slot_tag [DEPTH];
  int unsigned        n_held;

  rsp_t        pending_replies[$];
  row_t        plan[$];
  bit          quiet;
  int unsigned n_errors, n_inserts, n_extracts, n_full, n_empty, idle_cycles;

  sorted_event_priority_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic rsp_t queue_apply(req_t r);
    rsp_t        o;
    int unsigned pos;
    o = '0;
    if (r.cmd == CmdExtract) begin
      if (n_held == 0) begin
        o.status = StatusEmpty;
        return o;
      end
      o.status     = StatusOk;
      o.item_valid = 1'b1;
      o.out_key    = slot_key[0];
      o.out_tag    = slot_tag[0];
      for (int i = 1; i < n_held; i++) begin
        slot_key[i-1] = slot_key[i];
        slot_tag[i-1] = slot_tag[i];
      end
      n_held--;
      o.count = n_held[CountBits-1:0];
      return o;
    end
    if (n_held == DEPTH) begin
      o.status = StatusFull;
    end else begin
      if (n_held == 0 || r.key < slot_key[0]) begin
        pos = 0;
      end else begin
        pos = 1;
        while (pos < n_held && slot_key[pos] < r.key) pos++;
      end
      for (int i = n_held; i > pos; i--) begin
        slot_key[i] = slot_key[i-1];
        slot_tag[i] = slot_tag[i-1];
      end
      slot_key[pos] = r.key;
      slot_tag[pos] = r.tag;
      n_held++;
      o.status = StatusOk;
    end
    o.item_valid = 1'b1;
    o.out_key    = slot_key[0];
    o.out_tag    = slot_tag[0];
    o.count      = n_held[CountBits-1:0];
    return o;
  endfunction

  task automatic add_row(cmd_e c, logic [KeyBits-1:0] k, logic [TagBits-1:0] t,
                         bit typed = 1'b0, rsp_t e = NO_REPLY);
    row_t row;
    row.req   = '{cmd: c, key: k, tag: t};
    row.typed = typed;
    row.exp   = e;
    plan.push_back(row);
  endtask

  // one request through the handshake; the reply is predicted on acceptance
  task automatic issue(req_t r, bit typed, rsp_t typed_exp);
    rsp_t reply;
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    reply = queue_apply(r);
    if (r.cmd == CmdInsert) n_inserts++;
    else n_extracts++;
    if (reply.status == StatusFull) n_full++;
    if (reply.status == StatusEmpty) n_empty++;
    pending_replies.push_back(typed ? typed_exp : reply);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_replies.size() != 0);
  endtask

  task automatic check_reply(rsp_t got);
    rsp_t want;
    if (pending_replies.size() == 0) begin
      $error("reply with none outstanding: status=%0d key=%h", got.status, got.out_key);
      n_errors++;
      return;
    end
    want = pending_replies.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      n_errors++;
    end
    if (got.item_valid !== want.item_valid) begin
      $error("item_valid: expected %0b, got %0b", want.item_valid, got.item_valid);
      n_errors++;
    end
    if (got.out_key !== want.out_key) begin
      $error("out_key: expected %h, got %h", want.out_key, got.out_key);
      n_errors++;
    end
    if (got.out_tag !== want.out_tag) begin
      $error("out_tag: expected %h, got %h", want.out_tag, got.out_tag);
      n_errors++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      n_errors++;
    end
  endtask

  // result side: stall, check, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_reply(out_rsp_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("timeout: %0d replies outstanding", pending_replies.size());
        $display("sorted_event_priority_queue: mismatch");
        $finish;
      end
    end
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 9);
  end

  initial begin
    req_t        r;
    int unsigned mode, p_ins;
    for (int i = 0; i < DEPTH; i++) begin
      slot_key[i] = '0;
      slot_tag[i] = '0;
    end
    n_held = 0;

    add_row(CmdExtract, '0, '0, 1'b1, '{StatusEmpty, 1'b0, '0, '0, 7'd0});
    add_row(CmdInsert, '1, '1, 1'b1, '{StatusOk, 1'b1, '1, '1, 7'd1});
    add_row(CmdInsert, '0, '0, 1'b1, '{StatusOk, 1'b1, '0, '0, 7'd2});
    add_row(CmdInsert, '0, 16'h0001);
    add_row(CmdInsert, '0, 16'h0002);
    add_row(CmdExtract, '1, '1, 1'b1, '{StatusOk, 1'b1, '0, '0, 7'd3});
    add_row(CmdExtract, '0, '0);
    add_row(CmdInsert, 32'h8000_0000, 16'h8000);
    add_row(CmdInsert, 32'h0000_0001, 16'h5555);
    add_row(CmdInsert, 32'hAAAA_AAAA, 16'hAAAA);
    add_row(CmdInsert, 32'h5555_5555, 16'h5555);
    add_row(CmdInsert, '1, '0);
    for (int i = 0; i < 7; i++) add_row(CmdExtract, '0, '0);
    add_row(CmdExtract, '1, '1, 1'b1, '{StatusEmpty, 1'b0, '0, '0, 7'd0});
    add_row(CmdInsert, '0, '1, 1'b1, '{StatusOk, 1'b1, '0, '1, 7'd1});
    add_row(CmdInsert, '1, '0, 1'b1, '{StatusOk, 1'b1, '0, '1, 7'd2});
    add_row(CmdExtract, '0, '0, 1'b1, '{StatusOk, 1'b1, '0, '1, 7'd1});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) issue(plan[i].req, plan[i].typed, plan[i].exp);
    hold_until_drained();

    // epochs of fill-heavy, drain-heavy and balanced traffic
    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 300 && i < 600);
      mode  = (i / 96) % 3;
      p_ins = (mode == 0) ? 85 : (mode == 1) ? 20 : 50;
      if (i % 250 == 249) hold_until_drained();
      r.cmd = ($urandom_range(0, 99) < p_ins) ? CmdInsert : CmdExtract;
      r.tag = TagBits'($urandom);
      case ($urandom_range(0, 9))
        0: r.key = (n_held != 0) ? slot_key[0] : KeyBits'($urandom);
        1, 2: r.key = KeyBits'($urandom_range(0, 15));
        3: r.key = $urandom_range(0, 1) ? '1 : '0;
        default: r.key = KeyBits'($urandom);
      endcase
      issue(r, 1'b0, NO_REPLY);
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("covered %0d inserts and %0d extracts; %0d rejected as full, %0d on empty",
             n_inserts, n_extracts, n_full, n_empty);
    $display("%0d field errors", n_errors);
    if (n_errors == 0) begin
      $display("sorted_event_priority_queue: match");
    end else begin
      $display("sorted_event_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
